/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property on the rising edge, disabled while reset is asserted.
`define ASSERT_PROP(lbl, clk_sig, rst_n, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n) (prop)) \
		else $error("%m: property failed");

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk_sig, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication failed");

`endif

/* rtl/trcq_pkg.sv */
// ----------------------------------------------------------------------------
// trcq_pkg
// Types and constants shared by the tile collision query block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trcq_pkg;

	localparam int EDGE_W     = 24;
	localparam int MAP_REG_W  = 9;
	localparam int PX_W       = 8;
	localparam int COORD_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 2'd3;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_WR_READ,
		S_WR_WRITE,
		S_DIV_START,
		S_DIV_WAIT,
		S_CHECK,
		S_ROW_RD,
		S_COL,
		S_RESULT
	} ctrl_state_t;

	// Which span bound a division produces.
	typedef enum logic [1:0] {
		SPAN_X0,
		SPAN_Y0,
		SPAN_X1,
		SPAN_Y1
	} span_sel_t;

	typedef struct packed {
		logic      capture;
		logic      clr_step;
		logic      mem_rd_wr;
		logic      mem_wr_bit;
		logic      div_start;
		logic      div_store;
		span_sel_t div_sel;
		logic      scan_init;
		logic      mem_rd_scan;
		logic      next_col;
		logic      next_row;
		logic      set_res;
		logic      res_val;
		logic      load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_query;
		logic wr_in_map;
		logic div_busy;
		logic div_done;
		logic span_empty;
		logic span_off;
		logic bit_hit;
		logic x_last;
		logic y_last;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

/* rtl/tile_rect_collision_query.sv */
// ----------------------------------------------------------------------------
// tile_rect_collision_query
// Tile collision map with rectangle queries against solid or off-map tiles.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake               Payload
//   -------  ----------------------  -------------------------------------------
//   in       in_valid / in_ready     command, tile_col, tile_row, solid_value,
//                                    rect_left, rect_top, rect_right, rect_bottom
//   out      out_valid / out_ready   hit_solid (one per query transaction)
//   cfg      cfg_write_en            cfg_index, cfg_data
//
// After reset the map is cleared one row per cycle, all MAX_MAP_HEIGHT rows, with
// in_ready low. A write passes through dispatch, then, if it lands in the map, a
// row read and a row write. A query runs the four divisions in turn on the shared
// one-bit-per-cycle divider and, unless the span is empty or off the map, scans
// each covered row, a row read then each column, up to the first solid tile.
// A stalled out channel holds one finished result; the next query waits at its end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tile_rect_collision_query #(
	parameter int MAX_MAP_WIDTH  = 256,
	parameter int MAX_MAP_HEIGHT = 256,
	parameter int FRAC_BITS      = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [trcq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [trcq_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                command,
	input  logic [trcq_pkg::COORD_W-1:0]        tile_col,
	input  logic [trcq_pkg::COORD_W-1:0]        tile_row,
	input  logic                                solid_value,
	input  logic signed [trcq_pkg::EDGE_W-1:0]  rect_left,
	input  logic signed [trcq_pkg::EDGE_W-1:0]  rect_top,
	input  logic signed [trcq_pkg::EDGE_W-1:0]  rect_right,
	input  logic signed [trcq_pkg::EDGE_W-1:0]  rect_bottom,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit_solid
);
	import trcq_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	trcq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	trcq_dp #(
		.MAX_MAP_WIDTH  (MAX_MAP_WIDTH),
		.MAX_MAP_HEIGHT (MAX_MAP_HEIGHT),
		.FRAC_BITS      (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.command      (command),
		.tile_col     (tile_col),
		.tile_row     (tile_row),
		.solid_value  (solid_value),
		.rect_left    (rect_left),
		.rect_top     (rect_top),
		.rect_right   (rect_right),
		.rect_bottom  (rect_bottom),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit_solid    (hit_solid)
	);

	// A write transaction never produces a result.
	`ASSERT_PROP(a_write_no_result, clk, arst_n, (in_valid && in_ready && command == CMD_WRITE) |=> !$rose(out_valid))
	// A query keeps the input side closed while it is worked on.
	`ASSERT_PROP(a_query_busy, clk, arst_n, (in_valid && in_ready && command == CMD_QUERY) |=> !in_ready)
	// The divider is only started when idle.
	`ASSERT_IMPLY(a_div_idle, clk, arst_n, cmd.div_start, !sts.div_busy)
	// A result is only loaded when the output register can take it.
	`ASSERT_IMPLY(a_load_free, clk, arst_n, cmd.load_out, sts.out_free)

endmodule

`default_nettype wire

/* rtl/trcq_div.sv */
// ----------------------------------------------------------------------------
// trcq_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trcq_div #(
	parameter int DW = 21
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [DW-1:0]                dividend,
	input  logic [trcq_pkg::PX_W-1:0]    divisor,
	output logic                         busy,
	output logic                         done,
	output logic [DW-1:0]                quotient
);
	import trcq_pkg::*;

	localparam int CNT_W = $clog2(DW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PX_W-1:0]  rem_q;
	logic [PX_W-1:0]  den_q;
	logic [DW-1:0]    quo_q;
	logic [PX_W:0]    rem_sh;
	logic [PX_W:0]    rem_sub;
	logic             ge;

	assign rem_sh  = {rem_q, quo_q[DW-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[PX_W-1:0] : rem_sh[PX_W-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

/* rtl/trcq_dp.sv */
// ----------------------------------------------------------------------------
// trcq_dp
// Datapath: configuration, row-wide tile map, span division and tile scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trcq_dp #(
	parameter int MAX_MAP_WIDTH  = 256,
	parameter int MAX_MAP_HEIGHT = 256,
	parameter int FRAC_BITS      = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [trcq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [trcq_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                command,
	input  logic [trcq_pkg::COORD_W-1:0]        tile_col,
	input  logic [trcq_pkg::COORD_W-1:0]        tile_row,
	input  logic                                solid_value,
	input  logic signed [trcq_pkg::EDGE_W-1:0]  rect_left,
	input  logic signed [trcq_pkg::EDGE_W-1:0]  rect_top,
	input  logic signed [trcq_pkg::EDGE_W-1:0]  rect_right,
	input  logic signed [trcq_pkg::EDGE_W-1:0]  rect_bottom,
	input  trcq_pkg::dp_cmd_t                   cmd,
	output trcq_pkg::dp_sts_t                   sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit_solid
);
	import trcq_pkg::*;

	localparam int CW = (MAX_MAP_WIDTH > 1) ? $clog2(MAX_MAP_WIDTH) : 1;
	localparam int RW = (MAX_MAP_HEIGHT > 1) ? $clog2(MAX_MAP_HEIGHT) : 1;
	localparam int DW = EDGE_W + 1 - FRAC_BITS;
	localparam logic [MAP_REG_W-1:0] W_CAP =
		(MAX_MAP_WIDTH >= (1 << MAP_REG_W) - 1) ? {MAP_REG_W{1'b1}} : MAP_REG_W'(MAX_MAP_WIDTH);
	localparam logic [MAP_REG_W-1:0] H_CAP =
		(MAX_MAP_HEIGHT >= (1 << MAP_REG_W) - 1) ? {MAP_REG_W{1'b1}} : MAP_REG_W'(MAX_MAP_HEIGHT);

	// Configuration registers.
	logic [MAP_REG_W-1:0] map_w_q;
	logic [MAP_REG_W-1:0] map_h_q;
	logic [PX_W-1:0]      tile_w_q;
	logic [PX_W-1:0]      tile_h_q;
	logic [MAP_REG_W-1:0] eff_w;
	logic [MAP_REG_W-1:0] eff_h;

	// Captured transaction.
	logic                    cmd_q;
	logic [COORD_W-1:0]      wcol_q;
	logic [COORD_W-1:0]      wrow_q;
	logic                    wsolid_q;
	logic signed [EDGE_W-1:0] left_q;
	logic signed [EDGE_W-1:0] top_q;
	logic signed [EDGE_W-1:0] right_q;
	logic signed [EDGE_W-1:0] bottom_q;

	// Tile map, one row of solid bits per entry.
	logic [MAX_MAP_WIDTH-1:0] mem [MAX_MAP_HEIGHT];
	logic [MAX_MAP_WIDTH-1:0] row_q;
	logic [MAX_MAP_WIDTH-1:0] row_mod;
	logic [RW-1:0]            clr_q;
	logic                     mem_we;
	logic [RW-1:0]            mem_waddr;
	logic [MAX_MAP_WIDTH-1:0] mem_wdata;
	logic                     mem_re;
	logic [RW-1:0]            mem_raddr;
	logic [CW-1:0]            wcol_idx;
	logic [RW-1:0]            wrow_idx;

	// Span division.
	logic signed [EDGE_W:0]   edge_ext;
	logic signed [EDGE_W:0]   edge_sh;
	logic [DW-1:0]            div_mag;
	logic [PX_W-1:0]          div_px;
	logic [PX_W-1:0]          div_den;
	logic                     div_busy;
	logic                     div_done;
	logic [DW-1:0]            div_quo;
	logic                     neg_q;
	logic [DW-1:0]            span_val;
	logic signed [DW-1:0]     x0_q;
	logic signed [DW-1:0]     y0_q;
	logic signed [DW-1:0]     x1_q;
	logic signed [DW-1:0]     y1_q;
	logic signed [DW-1:0]     w_ext;
	logic signed [DW-1:0]     h_ext;

	// Scan and result.
	logic [CW-1:0] x_q;
	logic [RW-1:0] y_q;
	logic          res_q;
	logic          out_valid_q;
	logic          hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_w_q  <= MAP_REG_W'(256);
			map_h_q  <= MAP_REG_W'(256);
			tile_w_q <= PX_W'(16);
			tile_h_q <= PX_W'(16);
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_MAP_WIDTH:   map_w_q  <= cfg_data;
				CFG_MAP_HEIGHT:  map_h_q  <= cfg_data;
				CFG_TILE_WIDTH:  tile_w_q <= cfg_data[PX_W-1:0];
				CFG_TILE_HEIGHT: tile_h_q <= cfg_data[PX_W-1:0];
				default: ;
			endcase
		end
	end

	assign eff_w = (map_w_q > W_CAP) ? W_CAP : map_w_q;
	assign eff_h = (map_h_q > H_CAP) ? H_CAP : map_h_q;
	assign w_ext = $signed({{(DW-MAP_REG_W){1'b0}}, eff_w});
	assign h_ext = $signed({{(DW-MAP_REG_W){1'b0}}, eff_h});

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q    <= command;
			wcol_q   <= tile_col;
			wrow_q   <= tile_row;
			wsolid_q <= solid_value;
			left_q   <= rect_left;
			top_q    <= rect_top;
			right_q  <= rect_right;
			bottom_q <= rect_bottom;
		end
	end

	// Map access: clearing pass, read-modify-write of one bit, row reads for the scan.
	assign wcol_idx  = CW'(wcol_q);
	assign wrow_idx  = RW'(wrow_q);
	assign mem_we    = cmd.clr_step | cmd.mem_wr_bit;
	assign mem_waddr = cmd.clr_step ? clr_q : wrow_idx;
	assign mem_wdata = cmd.clr_step ? '0 : row_mod;
	assign mem_re    = cmd.mem_rd_wr | cmd.mem_rd_scan;
	assign mem_raddr = cmd.mem_rd_wr ? wrow_idx : y_q;

	always_comb begin
		row_mod           = row_q;
		row_mod[wcol_idx] = wsolid_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			row_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + RW'(1);
		end
	end

	// Floor division of a signed edge by the tile size in fixed point: drop the
	// fraction with an arithmetic shift, then divide the magnitude of the
	// non-negative value or of its one's complement by the pixel count.
	always_comb begin
		case (cmd.div_sel)
			SPAN_X0: edge_ext = {left_q[EDGE_W-1], left_q};
			SPAN_Y0: edge_ext = {top_q[EDGE_W-1], top_q};
			SPAN_X1: edge_ext = $signed({right_q[EDGE_W-1], right_q}) - 1'b1;
			SPAN_Y1: edge_ext = $signed({bottom_q[EDGE_W-1], bottom_q}) - 1'b1;
			default: edge_ext = '0;
		endcase
	end

	assign edge_sh = edge_ext >>> FRAC_BITS;
	assign div_mag = edge_sh[EDGE_W] ? ~edge_sh[DW-1:0] : edge_sh[DW-1:0];
	assign div_px  = (cmd.div_sel == SPAN_X0 || cmd.div_sel == SPAN_X1) ? tile_w_q : tile_h_q;
	assign div_den = (div_px == '0) ? PX_W'(1) : div_px;

	trcq_div #(
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_mag),
		.divisor  (div_den),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			neg_q <= edge_sh[EDGE_W];
		end
	end

	assign span_val = neg_q ? ~div_quo : div_quo;

	always_ff @(posedge clk) begin
		if (cmd.div_store) begin
			case (cmd.div_sel)
				SPAN_X0: x0_q <= $signed(span_val);
				SPAN_Y0: y0_q <= $signed(span_val);
				SPAN_X1: x1_q <= $signed(span_val);
				SPAN_Y1: y1_q <= $signed(span_val);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			x_q <= x0_q[CW-1:0];
			y_q <= y0_q[RW-1:0];
		end else if (cmd.next_row) begin
			x_q <= x0_q[CW-1:0];
			y_q <= y_q + RW'(1);
		end else if (cmd.next_col) begin
			x_q <= x_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			res_q <= cmd.res_val;
		end
	end

	// Output register, so the next transaction can enter while a result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			hit_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign hit_solid = hit_q;

	always_comb begin
		sts            = '0;
		sts.clr_last   = clr_q == RW'(MAX_MAP_HEIGHT - 1);
		sts.is_query   = cmd_q == CMD_QUERY;
		sts.wr_in_map  = ({1'b0, wcol_q} < eff_w) && ({1'b0, wrow_q} < eff_h);
		sts.div_busy   = div_busy;
		sts.div_done   = div_done;
		sts.span_empty = (x0_q > x1_q) || (y0_q > y1_q);
		sts.span_off   = x0_q[DW-1] || y0_q[DW-1] || (x1_q >= w_ext) || (y1_q >= h_ext);
		sts.bit_hit    = row_q[x_q];
		sts.x_last     = x_q == x1_q[CW-1:0];
		sts.y_last     = y_q == y1_q[RW-1:0];
		sts.out_free   = !out_valid_q || out_ready;
	end

endmodule

`default_nettype wire

/* rtl/trcq_ctrl.sv */
// ----------------------------------------------------------------------------
// trcq_ctrl
// Controller: sequences map clearing, tile writes, divisions and the scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trcq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  trcq_pkg::dp_sts_t sts,
	output trcq_pkg::dp_cmd_t cmd
);
	import trcq_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	span_sel_t   sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Bounds are produced in the order left, top, right, bottom.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= SPAN_X0;
		end else if (state_q == S_DISPATCH) begin
			sel_q <= SPAN_X0;
		end else if (cmd.div_store && sel_q != SPAN_Y1) begin
			sel_q <= span_sel_t'(sel_q + 2'd1);
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.div_sel = sel_q;
		in_ready    = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (sts.is_query) begin
					state_d = S_DIV_START;
				end else if (sts.wr_in_map) begin
					state_d = S_WR_READ;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_WR_READ: begin
				cmd.mem_rd_wr = 1'b1;
				state_d       = S_WR_WRITE;
			end
			S_WR_WRITE: begin
				cmd.mem_wr_bit = 1'b1;
				state_d        = S_IDLE;
			end
			S_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (sts.div_done) begin
					cmd.div_store = 1'b1;
					state_d       = (sel_q == SPAN_Y1) ? S_CHECK : S_DIV_START;
				end
			end
			S_CHECK: begin
				if (sts.span_empty) begin
					cmd.set_res = 1'b1;
					cmd.res_val = 1'b0;
					state_d     = S_RESULT;
				end else if (sts.span_off) begin
					cmd.set_res = 1'b1;
					cmd.res_val = 1'b1;
					state_d     = S_RESULT;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = S_ROW_RD;
				end
			end
			S_ROW_RD: begin
				cmd.mem_rd_scan = 1'b1;
				state_d         = S_COL;
			end
			S_COL: begin
				if (sts.bit_hit) begin
					cmd.set_res = 1'b1;
					cmd.res_val = 1'b1;
					state_d     = S_RESULT;
				end else if (sts.x_last) begin
					if (sts.y_last) begin
						cmd.set_res = 1'b1;
						cmd.res_val = 1'b0;
						state_d     = S_RESULT;
					end else begin
						cmd.next_row = 1'b1;
						state_d      = S_ROW_RD;
					end
				end else begin
					cmd.next_col = 1'b1;
				end
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* tb/tb_tile_rect_collision_query.sv */
// ----------------------------------------------------------------------------
// tb_tile_rect_collision_query
// Drives tile writes and rectangle queries into the collision map and checks
// every query answer against a behavioral map kept inside the testbench.
// Directed cases cover field extremes, empty spans, spans leaving the map,
// zero and oversized map registers, zero tile sizes, ignored writes, and
// resizing. A randomized part then runs several register settings with
// random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tile_rect_collision_query;

	import trcq_pkg::*;

	localparam int MAP_MAX_COLS   = 256;
	localparam int MAP_MAX_ROWS   = 256;
	localparam int FRAC           = 4;
	localparam int SETTLE_CYCLES  = 16;
	localparam int TAIL_CYCLES    = 200;
	localparam int STALL_LIMIT    = 200000;
	localparam int PHASE_ITEMS    = 75;
	localparam int RANDOM_PHASES  = 6;

	typedef struct {
		logic                     cmd;
		logic [COORD_W-1:0]       col;
		logic [COORD_W-1:0]       row;
		logic                     solid;
		logic signed [EDGE_W-1:0] left;
		logic signed [EDGE_W-1:0] top;
		logic signed [EDGE_W-1:0] right;
		logic signed [EDGE_W-1:0] bottom;
	} tile_txn_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic                     command = 1'b0;
	logic [COORD_W-1:0]       tile_col = '0;
	logic [COORD_W-1:0]       tile_row = '0;
	logic                     solid_value = 1'b0;
	logic signed [EDGE_W-1:0] rect_left = '0;
	logic signed [EDGE_W-1:0] rect_top = '0;
	logic signed [EDGE_W-1:0] rect_right = '0;
	logic signed [EDGE_W-1:0] rect_bottom = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic                     hit_solid;

	// Testbench copy of the map and the registers.
	bit                       solid_tiles [0:MAP_MAX_COLS*MAP_MAX_ROWS-1];
	logic [MAP_REG_W-1:0]     cfg_cols = 9'd256;
	logic [MAP_REG_W-1:0]     cfg_rows = 9'd256;
	logic [PX_W-1:0]          cfg_tile_w = 8'd16;
	logic [PX_W-1:0]          cfg_tile_h = 8'd16;

	bit                       hit_expected_q [$];
	int                       error_count = 0;
	int                       stall_cycles = 0;
	bit                       burst_mode = 1'b0;
	int                       last_solid_col = 0;
	int                       last_solid_row = 0;

	tile_rect_collision_query #(
		.MAX_MAP_WIDTH(MAP_MAX_COLS),
		.MAX_MAP_HEIGHT(MAP_MAX_ROWS),
		.FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.tile_col(tile_col),
		.tile_row(tile_row),
		.solid_value(solid_value),
		.rect_left(rect_left),
		.rect_top(rect_top),
		.rect_right(rect_right),
		.rect_bottom(rect_bottom),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit_solid(hit_solid)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Map prediction
	// ------------------------------------------------------------------

	function automatic longint eff_cols();
		return (cfg_cols > MAP_MAX_COLS) ? longint'(MAP_MAX_COLS) : longint'(cfg_cols);
	endfunction

	function automatic longint eff_rows();
		return (cfg_rows > MAP_MAX_ROWS) ? longint'(MAP_MAX_ROWS) : longint'(cfg_rows);
	endfunction

	function automatic longint tile_w_units();
		return longint'((cfg_tile_w == 0) ? 8'd1 : cfg_tile_w) << FRAC;
	endfunction

	function automatic longint tile_h_units();
		return longint'((cfg_tile_h == 0) ? 8'd1 : cfg_tile_h) << FRAC;
	endfunction

	// Division rounding toward minus infinity.
	function automatic longint floor_div(longint a, longint d);
		longint q;
		q = a / d;
		if ((a % d) != 0 && a < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic bit predict_hit(tile_txn_t t);
		longint tw, th, x0, x1, y0, y1;
		tw = tile_w_units();
		th = tile_h_units();
		x0 = floor_div(longint'(t.left), tw);
		y0 = floor_div(longint'(t.top), th);
		// The exclusive edges lose one LSB before they are mapped to tiles.
		x1 = floor_div(longint'(t.right) - 1, tw);
		y1 = floor_div(longint'(t.bottom) - 1, th);
		if (x0 > x1 || y0 > y1)
			return 1'b0;
		if (x0 < 0 || y0 < 0 || x1 >= eff_cols() || y1 >= eff_rows())
			return 1'b1;
		for (longint y = y0; y <= y1; y++)
			for (longint x = x0; x <= x1; x++)
				if (solid_tiles[y * MAP_MAX_COLS + x])
					return 1'b1;
		return 1'b0;
	endfunction

	function automatic void record_item(tile_txn_t t);
		if (t.cmd == CMD_WRITE) begin
			if (t.col < eff_cols() && t.row < eff_rows())
				solid_tiles[t.row * MAP_MAX_COLS + t.col] = t.solid;
		end else begin
			hit_expected_q.push_back(predict_hit(t));
		end
	endfunction

	function automatic void apply_config(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_MAP_WIDTH:   cfg_cols = data;
			CFG_MAP_HEIGHT:  cfg_rows = data;
			CFG_TILE_WIDTH:  cfg_tile_w = data[PX_W-1:0];
			CFG_TILE_HEIGHT: cfg_tile_h = data[PX_W-1:0];
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Item builders
	// ------------------------------------------------------------------

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst_mode || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic longint pick_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return 0;
		if (r < 88)
			return longint'($urandom_range(1, 3));
		if (r < 98)
			return longint'($urandom_range(4, 12));
		return longint'($urandom_range(13, 40));
	endfunction

	function automatic tile_txn_t noise_item();
		tile_txn_t t;
		t.cmd = $urandom;
		t.col = $urandom;
		t.row = $urandom;
		t.solid = $urandom;
		t.left = $urandom;
		t.top = $urandom;
		t.right = $urandom;
		t.bottom = $urandom;
		return t;
	endfunction

	function automatic tile_txn_t write_txn(int col, int row, bit solid);
		tile_txn_t t;
		t = noise_item();
		t.cmd = CMD_WRITE;
		t.col = col;
		t.row = row;
		t.solid = solid;
		return t;
	endfunction

	function automatic tile_txn_t query_txn(longint l, longint t_, longint r, longint b);
		tile_txn_t t;
		t = noise_item();
		t.cmd = CMD_QUERY;
		t.left = l;
		t.top = t_;
		t.right = r;
		t.bottom = b;
		return t;
	endfunction

	// Query covering exactly the given tile span, with random sub-tile offsets.
	function automatic tile_txn_t tile_rect_query(longint c0, longint r0,
			longint ncols, longint nrows);
		longint tw, th;
		tw = tile_w_units();
		th = tile_h_units();
		return query_txn(
			c0 * tw + longint'($urandom_range(0, int'(tw) - 1)),
			r0 * th + longint'($urandom_range(0, int'(th) - 1)),
			(c0 + ncols - 1) * tw + 1 + longint'($urandom_range(0, int'(tw) - 1)),
			(r0 + nrows - 1) * th + 1 + longint'($urandom_range(0, int'(th) - 1)));
	endfunction

	function automatic tile_txn_t random_item();
		tile_txn_t t;
		int pick;
		longint cols, rows, c0, r0;
		pick = $urandom_range(0, 99);
		cols = eff_cols();
		rows = eff_rows();
		if (pick < 15)
			return noise_item();
		if (pick < 50) begin
			t = noise_item();
			t.cmd = CMD_WRITE;
			if (cols > 0)
				t.col = $urandom_range(0, int'((cols > 255) ? 255 : cols));
			if (rows > 0)
				t.row = $urandom_range(0, int'((rows > 255) ? 255 : rows));
			t.solid = ($urandom_range(0, 99) < 45);
			if (t.solid) begin
				last_solid_col = t.col;
				last_solid_row = t.row;
			end
			return t;
		end
		if (pick < 75) begin
			c0 = longint'(last_solid_col) - longint'($urandom_range(0, 2));
			r0 = longint'(last_solid_row) - longint'($urandom_range(0, 2));
		end else begin
			c0 = longint'($urandom_range(0, int'(cols) + 1)) - 1;
			r0 = longint'($urandom_range(0, int'(rows) + 1)) - 1;
		end
		return tile_rect_query(c0, r0, pick_span(), pick_span());
	endfunction

	// ------------------------------------------------------------------
	// Channel tasks
	// ------------------------------------------------------------------

	// Valid is lowered only when a gap follows, so back-to-back items keep it high.
	task automatic send_item(input tile_txn_t t);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= t.cmd;
		tile_col <= t.col;
		tile_row <= t.row;
		solid_value <= t.solid;
		rect_left <= t.left;
		rect_top <= t.top;
		rect_right <= t.right;
		rect_bottom <= t.bottom;
		do @(posedge clk); while (!in_ready);
		record_item(t);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (hit_expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		apply_config(idx, data);
		cfg_write_en <= 1'b0;
		@(posedge clk);
	endtask

	// Writes produce no answer, so a trailing write may still be in flight.
	task automatic configure(input int cols, input int rows, input int tw, input int th);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(CFG_MAP_WIDTH, cols);
		write_reg(CFG_MAP_HEIGHT, rows);
		write_reg(CFG_TILE_WIDTH, tw);
		write_reg(CFG_TILE_HEIGHT, th);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_full_map_scan();
		// Covers every tile of the cleared 256 x 256 map.
		send_item(query_txn(0, 0, 65536, 65536));
	endtask

	task automatic test_field_extremes();
		send_item(write_txn(255, 255, 1'b1));
		send_item(write_txn(0, 0, 1'b1));
		send_item(tile_rect_query(255, 255, 1, 1));
		send_item(query_txn(-8388608, -8388608, 8388607, 8388607));
		send_item(query_txn(8388607, 8388607, -8388608, -8388608));
		send_item(write_txn(0, 0, 1'b0));
		send_item(query_txn(0, 0, 0, 0));
		send_item(query_txn(0, 0, 1, 1));
	endtask

	task automatic test_span_off_map();
		send_item(query_txn(-1, 0, 16, 16));
		send_item(tile_rect_query(255, 10, 2, 1));
	endtask

	task automatic test_oversize_map();
		configure(511, 300, 16, 16);
		send_item(tile_rect_query(254, 254, 2, 2));
		send_item(tile_rect_query(255, 0, 2, 1));
	endtask

	task automatic test_zero_map();
		configure(0, 0, 16, 16);
		send_item(write_txn(0, 0, 1'b1));
		send_item(tile_rect_query(0, 0, 1, 1));
		send_item(query_txn(0, 0, 0, 0));
	endtask

	task automatic test_write_outside();
		configure(4, 4, 16, 16);
		send_item(write_txn(5, 1, 1'b1));
		send_item(write_txn(1, 5, 1'b1));
		configure(8, 8, 16, 16);
		send_item(tile_rect_query(5, 1, 1, 1));
		send_item(tile_rect_query(0, 0, 2, 6));
	endtask

	task automatic test_zero_tile();
		configure(8, 8, 0, 0);
		send_item(write_txn(3, 2, 1'b1));
		send_item(query_txn(3 * 16 + 5, 2 * 16, 3 * 16 + 6, 2 * 16 + 1));
		send_item(query_txn(2 * 16, 2 * 16, 3 * 16, 3 * 16));
	endtask

	task automatic test_resize_keeps_map();
		configure(2, 2, 16, 16);
		send_item(write_txn(1, 1, 1'b1));
		configure(256, 256, 16, 16);
		send_item(tile_rect_query(1, 1, 1, 1));
		send_item(tile_rect_query(255, 255, 1, 1));
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: configure(256, 256, 16, 16);
				1: configure(1, 1, 1, 1);
				2: configure(511, 511, 255, 255);
				3: configure($urandom_range(1, 12), $urandom_range(1, 12), 0,
					$urandom_range(0, 255));
				4: configure($urandom_range(2, 40), $urandom_range(2, 40),
					$urandom_range(1, 32), $urandom_range(1, 32));
				default: configure($urandom_range(257, 511), 256,
					$urandom_range(1, 4), $urandom_range(1, 4));
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				burst_mode = (i >= PHASE_ITEMS / 4 && i < PHASE_ITEMS / 4 + 15);
				// Hold the sender once per phase until every answer is back.
				if (i == PHASE_ITEMS / 2) begin
					wait_drained();
					@(posedge clk);
				end
				send_item(random_item());
			end
			burst_mode = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver, checker and watchdog
	// ------------------------------------------------------------------

	initial begin
		int n;
		forever begin
			n = pick_gap();
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	always @(posedge clk) begin : check_results
		bit want;
		if (arst_n && out_valid && out_ready) begin
			if (hit_expected_q.size() == 0) begin
				$display("%0t: unexpected result transaction, expected none, actual hit_solid=%0b",
					$time, hit_solid);
				error_count++;
			end else begin
				want = hit_expected_q.pop_front();
				if (hit_solid !== want) begin
					$display("%0t: hit_solid mismatch, expected %0b, actual %0b",
						$time, want, hit_solid);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_full_map_scan();
		test_field_extremes();
		test_span_off_map();
		test_oversize_map();
		test_zero_map();
		test_write_outside();
		test_zero_tile();
		test_resize_keeps_map();
		test_random_traffic();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
